>>> rtl/window_average_then_smoothing_core_assert.svh
// assertion macros shared by the core and its lanes
`ifndef WINDOW_AVERAGE_THEN_SMOOTHING_CORE_ASSERT_SVH
`define WINDOW_AVERAGE_THEN_SMOOTHING_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define WASC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("wasc assertion failed");
// next-cycle implication
`define WASC_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("wasc assertion failed");
`else
`define WASC_ASSERT_IMP(lbl, pre, post)
`define WASC_ASSERT_NXT(lbl, pre, post)
`endif

`endif

>>> rtl/wasc_pkg.sv
package wasc_pkg;

  localparam int DATA_W   = 16;
  localparam int AXES     = 3;
  localparam int WEIGHT_W = 17;
  localparam int FRAC_W   = 16;
  localparam int STATE_W  = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(6554);

  localparam int DEF_WINDOW_DEPTH = 128;
  localparam int DEF_CNT_W        = $clog2(DEF_WINDOW_DEPTH + 1);
  localparam int DEF_SUM_W        = DATA_W + DEF_CNT_W;

  typedef struct packed {
    logic                start;
    logic                first;
    logic [WEIGHT_W-1:0] weight;
  } lane_ctl_t;

endpackage

>>> rtl/wasc_sample_if.sv
interface wasc_sample_if;
  import wasc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample_x;
  logic signed [DATA_W-1:0] sample_y;
  logic signed [DATA_W-1:0] sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink (input valid, input sample_x, input sample_y, input sample_z,
                output ready);
endinterface

>>> rtl/wasc_result_if.sv
interface wasc_result_if;
  import wasc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] smoothed_x;
  logic signed [DATA_W-1:0] smoothed_y;
  logic signed [DATA_W-1:0] smoothed_z;

  modport source (output valid, output smoothed_x, output smoothed_y, output smoothed_z,
                  input ready);
  modport sink (input valid, input smoothed_x, input smoothed_y, input smoothed_z,
                output ready);
endinterface

>>> rtl/wasc_cfg_if.sv
interface wasc_cfg_if;
  import wasc_pkg::*;

  logic                valid;
  logic                ready;
  logic [WEIGHT_W-1:0] smoothing_weight;

  modport source (output valid, output smoothing_weight, input ready);
  modport sink (input valid, input smoothing_weight, output ready);
endinterface

>>> rtl/wasc_ram.sv
module wasc_ram #(
  parameter int WIDTH = wasc_pkg::AXES * wasc_pkg::DATA_W,
  parameter int DEPTH = wasc_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/wasc_lane.sv
`include "window_average_then_smoothing_core_assert.svh"

module wasc_lane #(
  parameter int SUM_W = wasc_pkg::DEF_SUM_W,
  parameter int CNT_W = wasc_pkg::DEF_CNT_W
) (
  input  logic                             clk,
  input  logic                             rst,
  input  wasc_pkg::lane_ctl_t              ctl,
  input  logic signed [SUM_W-1:0]          sum,
  input  logic [CNT_W-1:0]                 count,
  output logic                             busy,
  output logic signed [wasc_pkg::DATA_W-1:0] result
);
  import wasc_pkg::*;

  localparam int D_W    = STATE_W + 2;
  localparam int HI_W   = D_W + 1;
  localparam int STEP_W = $clog2((SUM_W > WEIGHT_W) ? SUM_W : WEIGHT_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_AVG  = 3'd2;
  localparam logic [2:0] ST_DIFF = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]                 state;
  logic [STEP_W-1:0]          step;
  logic                       neg;
  logic                       first;
  logic [SUM_W-1:0]           mag;
  logic [CNT_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt_reg;
  logic signed [DATA_W-1:0]   avg;
  logic signed [D_W-1:0]      diff;
  logic signed [HI_W-1:0]     hi;
  logic [WEIGHT_W-1:0]        lo;
  logic signed [STATE_W-1:0]  smooth;

  logic [CNT_W:0]             trial;
  logic                       ge;
  logic [DATA_W:0]            quot;
  logic [DATA_W:0]            avg_wide;
  logic signed [STATE_W-1:0]  avg_q;
  logic signed [HI_W-1:0]     mul_add;
  logic signed [STATE_W-1:0]  prod_q;
  logic signed [DATA_W-1:0]   smooth_int;

  assign busy = (state != ST_IDLE);

  // one quotient bit per cycle
  assign trial = {rem, mag[SUM_W-1]};
  assign ge    = (trial >= {1'b0, cnt_reg});

  assign quot     = mag[DATA_W:0];
  assign avg_wide = neg ? (~quot + 1'b1) : quot;
  assign avg_q    = {avg, {FRAC_W{1'b0}}};

  // shift-add multiply, weight bits consumed lsb first
  assign mul_add = hi + (lo[0] ? {diff[D_W-1], diff} : '0);

  // product >> 16 with round-half-up folded into the update
  assign prod_q = STATE_W'({hi, lo[WEIGHT_W-1:FRAC_W]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_AVG;
          end
        end
        ST_AVG: begin
          state <= ST_DIFF;
        end
        ST_DIFF: begin
          state <= first ? ST_IDLE : ST_MUL;
        end
        ST_MUL: begin
          if (step == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          neg     <= sum[SUM_W-1];
          mag     <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
          rem     <= '0;
          cnt_reg <= count;
          first   <= ctl.first;
          lo      <= ctl.weight;
          step    <= STEP_W'(SUM_W - 1);
        end
      end
      ST_DIV: begin
        rem  <= ge ? CNT_W'(trial - {1'b0, cnt_reg}) : trial[CNT_W-1:0];
        mag  <= {mag[SUM_W-2:0], ge};
        step <= step - 1'b1;
      end
      ST_AVG: begin
        avg <= avg_wide[DATA_W-1:0];
      end
      ST_DIFF: begin
        diff <= D_W'(avg_q) - D_W'(smooth);
        hi   <= '0;
        step <= STEP_W'(WEIGHT_W - 1);
        if (first) begin
          smooth <= avg_q;
        end
      end
      ST_MUL: begin
        hi   <= {mul_add[HI_W-1], mul_add[HI_W-1:1]};
        lo   <= {mul_add[0], lo[WEIGHT_W-1:1]};
        step <= step - 1'b1;
      end
      ST_FIN: begin
        smooth <= smooth + prod_q + STATE_W'(lo[FRAC_W-1]);
      end
      default: begin
      end
    endcase
  end

  // round half up, clamp at the top of the range
  assign smooth_int = smooth[STATE_W-1:FRAC_W];
  assign result = (smooth[FRAC_W-1] && (smooth_int != {1'b0, {(DATA_W-1){1'b1}}}))
                ? smooth_int + 1'b1 : smooth_int;

  `WASC_ASSERT_IMP(a_start_when_idle, ctl.start, state == ST_IDLE)
  `WASC_ASSERT_IMP(a_div_nonzero, state == ST_DIV, cnt_reg != '0)
  `WASC_ASSERT_IMP(a_rem_below_count, state == ST_DIV, rem < cnt_reg)

endmodule

>>> rtl/window_average_then_smoothing_core.sv
// structure: each axis lane runs a bit-serial divider (SUM_W steps, where
//   SUM_W = 16 + clog2(WINDOW_DEPTH+1)) followed by a bit-serial weight multiplier (17 steps);
//   the first sample skips the multiplier; a new sample is accepted only after the
//   previous result has been loaded into the output register
// reset: synchronous rst clears sums, counts, ring position and output valid, and reloads
//   the weight with 6554; the window memory is not cleared, no clearing pass
`include "window_average_then_smoothing_core_assert.svh"

module window_average_then_smoothing_core #(
  parameter int WINDOW_DEPTH = wasc_pkg::DEF_WINDOW_DEPTH
) (
  input logic           clk,
  input logic           rst,
  wasc_sample_if.sink   sample_in,
  wasc_result_if.source result_out,
  wasc_cfg_if.sink      cfg_wr
);
  import wasc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = DATA_W + CNT_W;
  localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ROW_W = AXES * DATA_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  logic [1:0]                state;
  logic [WEIGHT_W-1:0]       weight;
  logic [POS_W-1:0]          pos;
  logic [CNT_W-1:0]          fill;
  logic                      started;
  logic signed [SUM_W-1:0]   sums     [AXES];
  logic signed [SUM_W-1:0]   sum_next [AXES];
  logic signed [DATA_W-1:0]  samp     [AXES];
  logic signed [DATA_W-1:0]  in_vec   [AXES];
  logic signed [DATA_W-1:0]  old      [AXES];
  logic signed [DATA_W-1:0]  lane_res [AXES];
  logic [AXES-1:0]           busy;
  logic [ROW_W-1:0]          rd_row;
  logic [ROW_W-1:0]          wr_row;
  logic                      full;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      load;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_x;
  logic signed [DATA_W-1:0]  out_y;
  logic signed [DATA_W-1:0]  out_z;
  lane_ctl_t                 lane_ctl;

  assign cfg_wr.ready    = 1'b1;
  assign sample_in.ready = (state == ST_IDLE);
  assign accept          = sample_in.valid && sample_in.ready;

  assign in_vec[0] = sample_in.sample_x;
  assign in_vec[1] = sample_in.sample_y;
  assign in_vec[2] = sample_in.sample_z;

  assign full       = (fill == CNT_W'(WINDOW_DEPTH));
  assign count_next = full ? fill : fill + 1'b1;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      old[a] = rd_row[a*DATA_W +: DATA_W];
      wr_row[a*DATA_W +: DATA_W] = samp[a];
      // drop the overwritten entry once the window is full
      sum_next[a] = sums[a]
                  - (full ? {{(SUM_W-DATA_W){old[a][DATA_W-1]}}, old[a]} : '0)
                  + {{(SUM_W-DATA_W){samp[a][DATA_W-1]}}, samp[a]};
    end
  end

  // read issued at the transaction, old row lands for the update cycle
  wasc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (state == ST_UPD),
    .waddr (pos),
    .wdata (wr_row),
    .raddr (pos),
    .rdata (rd_row)
  );

  assign lane_ctl.start  = (state == ST_UPD);
  assign lane_ctl.first  = !started;
  assign lane_ctl.weight = weight;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    wasc_lane #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .sum    (sum_next[g]),
      .count  (count_next),
      .busy   (busy[g]),
      .result (lane_res[g])
    );
  end

  assign load = (state == ST_RUN) && !busy[0] && (!out_valid || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      weight    <= WEIGHT_RESET;
      pos       <= '0;
      fill      <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sums[a] <= '0;
      end
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        weight <= (cfg_wr.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                         : cfg_wr.smoothing_weight;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          for (int a = 0; a < AXES; a++) begin
            sums[a] <= sum_next[a];
          end
          pos     <= (pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos + 1'b1;
          fill    <= count_next;
          started <= 1'b1;
          state   <= ST_RUN;
        end
        ST_RUN: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int a = 0; a < AXES; a++) begin
        samp[a] <= in_vec[a];
      end
    end
    if (load) begin
      out_x <= lane_res[0];
      out_y <= lane_res[1];
      out_z <= lane_res[2];
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.smoothed_x = out_x;
  assign result_out.smoothed_y = out_y;
  assign result_out.smoothed_z = out_z;

  `WASC_ASSERT_NXT(a_upd_after_accept, accept, state == ST_UPD)
  `WASC_ASSERT_IMP(a_fill_bound, 1'b1, fill <= CNT_W'(WINDOW_DEPTH))
  `WASC_ASSERT_IMP(a_lanes_lockstep, 1'b1, (busy == '0) || (busy == '1))
  `WASC_ASSERT_IMP(a_load_started, load, started)

endmodule

>>> dv/tb_window_average_then_smoothing_core.sv
module tb_window_average_then_smoothing_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wasc_pkg::*;

  localparam int WINDOW = DEF_WINDOW_DEPTH;

  typedef logic [AXES-1:0][DATA_W-1:0] axis_vec_t;

  logic clk;
  logic rst;

  wasc_sample_if smp_if ();
  wasc_result_if res_if ();
  wasc_cfg_if    cfg_if ();

  window_average_then_smoothing_core #(
    .WINDOW_DEPTH(WINDOW)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .sample_in (smp_if),
    .result_out(res_if),
    .cfg_wr    (cfg_if)
  );

  // predictor state
  logic [WEIGHT_W-1:0] weight_reg;
  axis_vec_t           ring [WINDOW];
  int unsigned         ring_pos;
  int unsigned         ring_fill;
  longint              axis_sum [AXES];
  longint              smooth_state [AXES];
  bit                  smoothing_started;

  axis_vec_t smoothed_q [$];
  int        err_count;
  bit        idle_on;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic axis_vec_t smooth_step(axis_vec_t smp);
    axis_vec_t res;
    longint    w;
    longint    avg;
    longint    acc;
    longint    r;
    bit        full;
    int        a;
    w = (weight_reg > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_reg);
    full = (ring_fill >= WINDOW);
    for (a = 0; a < AXES; a++) begin
      // full window: drop the entry being overwritten
      if (full) axis_sum[a] -= longint'($signed(ring[ring_pos][a]));
      axis_sum[a] += longint'($signed(smp[a]));
    end
    ring[ring_pos] = smp;
    ring_pos = (ring_pos + 1) % WINDOW;
    if (!full) ring_fill++;
    for (a = 0; a < AXES; a++) begin
      avg = axis_sum[a] / longint'(ring_fill);
      if (!smoothing_started) begin
        smooth_state[a] = avg * 65536;
      end else begin
        acc = w * (avg * 65536) + (65536 - w) * smooth_state[a];
        smooth_state[a] = (acc + 32768) >>> FRAC_W;
      end
      r = (smooth_state[a] + 32768) >>> FRAC_W;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      res[a] = r[DATA_W-1:0];
    end
    smoothing_started = 1'b1;
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_axis();
    logic [DATA_W-1:0] v;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      v = DATA_W'($urandom);
    end else if (pick < 75) begin
      case ($urandom_range(0, 4))
        0: v = 16'h7fff;
        1: v = 16'h8000;
        2: v = 16'h0000;
        3: v = 16'hffff;
        default: v = 16'h0001;
      endcase
    end else begin
      v = DATA_W'(int'($urandom_range(0, 600)) - 300);
    end
    return v;
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    logic [WEIGHT_W-1:0] w;
    case ($urandom_range(0, 6))
      0: w = '0;
      1: w = WEIGHT_W'(1);
      2: w = WEIGHT_W'(65535);
      3: w = WEIGHT_ONE;
      4: w = '1;
      5: w = WEIGHT_W'($urandom_range(0, 131071));
      default: w = WEIGHT_W'($urandom_range(0, 65536));
    endcase
    return w;
  endfunction

  task automatic send_sample(input int x, input int y, input int z);
    axis_vec_t smp;
    smp = {DATA_W'(z), DATA_W'(y), DATA_W'(x)};
    if (idle_on && $urandom_range(0, 4) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    smp_if.valid    <= 1'b1;
    smp_if.sample_x <= smp[0];
    smp_if.sample_y <= smp[1];
    smp_if.sample_z <= smp[2];
    do @(posedge clk); while (!smp_if.ready);
    smoothed_q.push_back(smooth_step(smp));
  endtask

  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_weight(input logic [WEIGHT_W-1:0] w);
    wait_drained();
    cfg_if.valid            <= 1'b1;
    cfg_if.smoothing_weight <= w;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    weight_reg = w;
  endtask

  // reset weight, first average taken as is, field extremes
  task automatic test_reset_weight();
    send_sample(32767, -32768, 0);
    send_sample(-32768, 32767, -1);
    send_sample(0, 0, 0);
    send_sample(1, -1, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, 32767, 32767);
  endtask

  // zero weight, weight of one, and weights above one
  task automatic test_weight_extremes();
    write_weight('0);
    send_sample(1000, -1000, 32767);
    send_sample(-32768, 5, 7);
    send_sample(12, -12, 0);
    write_weight(WEIGHT_ONE);
    send_sample(32767, -32768, 100);
    send_sample(-3, 3, -100);
    send_sample(0, -32768, 32767);
    write_weight('1);
    send_sample(-32768, 32767, 1);
    send_sample(32767, -32768, -1);
    send_sample(7, -7, 0);
    write_weight(WEIGHT_W'(65537));
    send_sample(-1, 1, 2);
    send_sample(32767, 32767, -32768);
  endtask

  // half weight puts the rounding on exact halves
  task automatic test_rounding();
    write_weight(WEIGHT_W'(32768));
    send_sample(1, -1, 0);
    send_sample(0, 0, 1);
    send_sample(-1, 1, -1);
    send_sample(2, -3, 3);
    send_sample(-3, 2, -2);
  endtask

  task automatic test_random_weights();
    int phase;
    int n;
    int i;
    for (phase = 0; phase < 6; phase++) begin
      write_weight(pick_weight());
      n = $urandom_range(100, 160);
      for (i = 0; i < n; i++) begin
        // sender holds off until the pipeline is empty
        if (phase == 2 && i == n / 2) wait_drained();
        send_sample(rand_axis(), rand_axis(), rand_axis());
      end
    end
  endtask

  task automatic test_no_idle();
    int i;
    write_weight(pick_weight());
    idle_on = 1'b0;
    for (i = 0; i < 150; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
  endtask

  // result sink with random stall bursts
  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 19) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    axis_vec_t got;
    axis_vec_t want;
    int        a;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.smoothed_z, res_if.smoothed_y, res_if.smoothed_x};
      if (smoothed_q.size() == 0) begin
        $display("%0t: unexpected result transaction x=%0d y=%0d z=%0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]));
        err_count++;
      end else begin
        want = smoothed_q.pop_front();
        for (a = 0; a < AXES; a++) begin
          if (got[a] !== want[a]) begin
            $display("%0t: axis %0d mismatch expected %0d actual %0d", $time, a,
                     $signed(want[a]), $signed(got[a]));
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    smp_if.valid = 1'b0;
    smp_if.sample_x = '0;
    smp_if.sample_y = '0;
    smp_if.sample_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.smoothing_weight = '0;
    err_count = 0;
    idle_on = 1'b1;
    weight_reg = WEIGHT_RESET;
    ring_pos = 0;
    ring_fill = 0;
    smoothing_started = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      axis_sum[a] = 0;
      smooth_state[a] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_weight();
    test_weight_extremes();
    test_rounding();
    test_random_weights();
    test_no_idle();

    wait_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0 && smoothed_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
